@@ rtl/sitda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sitda_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_WIDTH        = 32;
    localparam int CHAR_WIDTH      = 8;
    localparam int BCD_DIGIT_W     = 4;

    localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 8'd48;

    // shift-and-add-3: a digit of five or more gets three added before the shift,
    // so that it carries into the next digit at ten
    localparam logic [BCD_DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [BCD_DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

    // decimal digits of 2^(w-1), the largest magnitude: floor((w-1)*log10(2)) + 1
    function automatic int dec_digits(input int w);
        return (((w - 1) * 1233) >> 12) + 1;
    endfunction

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic convert;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic negative;
        logic conv_done;
        logic digits_done;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/sitda_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sitda_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire sitda_pkg::t_dp_status i_status,
    output sitda_pkg::t_dp_cmd         o_cmd,
    output logic                       o_busy
);
    import sitda_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                if (i_status.conv_done) begin
                    n_state = i_status.negative ? S_SIGN : S_EMIT;
                end else begin
                    o_cmd.convert = 1'b1;
                end
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.digits_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/sitda_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sitda_dp #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [sitda_pkg::IN_WIDTH-1:0] i_value,
    input  wire sitda_pkg::t_dp_cmd                   i_cmd,
    output sitda_pkg::t_dp_status                     o_status,
    output logic                                      o_valid,
    output logic [sitda_pkg::CHAR_WIDTH-1:0]          o_text_char,
    output logic                                      o_last_char
);
    import sitda_pkg::*;

    localparam int NUM_DIGITS = dec_digits(VALUE_WIDTH);
    localparam int BCD_W      = NUM_DIGITS * BCD_DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    logic [VALUE_WIDTH-1:0] w_x;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic [BCD_W-1:0]       w_adj;
    logic [BCD_DIGIT_W-1:0] w_top;
    logic                   w_is_last;

    logic [VALUE_WIDTH-1:0] r_bin;
    logic [BCD_W-1:0]       r_bcd;
    logic                   r_neg;
    logic [CNT_W-1:0]       r_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_cnt;
    logic                   r_seen;
    logic                   r_valid;
    logic [CHAR_WIDTH-1:0]  r_char;
    logic                   r_last;

    // the word carries IN_WIDTH bits; a wider value is zero above them
    generate
        if (VALUE_WIDTH <= IN_WIDTH) begin : g_narrow
            assign w_x = i_value[VALUE_WIDTH-1:0];
        end else begin : g_wide
            assign w_x = {{(VALUE_WIDTH - IN_WIDTH){1'b0}}, i_value};
        end
    endgenerate

    // unsigned magnitude, so the most negative value keeps its full size
    assign w_mag = w_x[VALUE_WIDTH-1] ? (~w_x + {{(VALUE_WIDTH - 1){1'b0}}, 1'b1}) : w_x;

    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*BCD_DIGIT_W +: BCD_DIGIT_W] >= DIGIT_ADJ_MIN) begin
                w_adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] =
                    r_bcd[d*BCD_DIGIT_W +: BCD_DIGIT_W] + DIGIT_ADJ;
            end else begin
                w_adj[d*BCD_DIGIT_W +: BCD_DIGIT_W] = r_bcd[d*BCD_DIGIT_W +: BCD_DIGIT_W];
            end
        end
    end

    assign w_top     = r_bcd[BCD_W-1 -: BCD_DIGIT_W];
    assign w_is_last = (r_dig_cnt == DIG_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin     <= w_mag;
            r_bcd     <= '0;
            r_neg     <= w_x[VALUE_WIDTH-1];
            r_bit_cnt <= CNT_W'(VALUE_WIDTH);
            r_dig_cnt <= DIG_CNT_W'(NUM_DIGITS);
            r_seen    <= 1'b0;
        end else if (i_cmd.convert) begin
            r_bcd     <= {w_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            r_bin     <= {r_bin[VALUE_WIDTH-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - CNT_W'(1);
        end else if (i_cmd.emit_digit) begin
            // advance to the next digit, most significant first
            r_bcd     <= r_bcd << BCD_DIGIT_W;
            r_dig_cnt <= r_dig_cnt - DIG_CNT_W'(1);
            r_seen    <= r_seen | (w_top != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else begin
            r_char <= CHAR_ZERO + CHAR_WIDTH'(w_top);
            r_last <= w_is_last;
        end
    end

    // drop leading zeros, but always keep the units digit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit_sign
                     | (i_cmd.emit_digit & (r_seen | (w_top != '0) | w_is_last));
        end
    end

    assign o_status.negative    = r_neg;
    assign o_status.conv_done   = (r_bit_cnt == '0);
    assign o_status.digits_done = w_is_last;

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Output: character slots follow one a cycle once the conversion is done, a minus sign first
// if negative, then D digit slots, D = decimal digits of 2^(VALUE_WIDTH-1); a skipped leading
// zero leaves its slot empty. Start is taken only while idle, so a new number waits until busy
// drops after the bit-a-cycle shift-and-add-3 loop and the digit-a-cycle readout.
// Reset: synchronous, active low; clears the controller and strobe.
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic signed [sitda_pkg::IN_WIDTH-1:0] i_value,
    output logic                                      o_valid,
    output logic [sitda_pkg::CHAR_WIDTH-1:0]          o_text_char,
    output logic                                      o_last_char
);
    import sitda_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    sitda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    sitda_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted word");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |=> !o_valid)
        else $error("word strobed straight after the last character");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_text_char == CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign marked as last character");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_char) |-> busy)
        else $error("block idle while a number is still being emitted");

endmodule

`default_nettype wire
